// ===== rtl/rgbw_enc_pkg.sv =====
// Types and constants shared by the RGBW LED strip slot encoder.
package rgbw_enc_pkg;

   localparam int MAX_LEDS = 64;
   localparam int MEM_AW   = $clog2(MAX_LEDS);
   localparam int LED_W    = 7;
   localparam int BIT_W    = 5;
   localparam int DUTY_W   = 16;
   localparam int CSR_W    = 16;
   localparam int WORD_W   = 32;

   localparam logic [LED_W-1:0] MAX_LEDS_V = LED_W'(MAX_LEDS);
   localparam logic [BIT_W-1:0] BIT_TOP    = BIT_W'(WORD_W - 1);

   // Commands carried by an input item
   localparam logic [1:0] CMD_SET_ONE   = 2'd0;
   localparam logic [1:0] CMD_SET_ALL   = 2'd1;
   localparam logic [1:0] CMD_SET_RANGE = 2'd2;
   localparam logic [1:0] CMD_TICK      = 2'd3;

   // Register indexes on the csr port
   localparam logic [1:0] CSR_LED_COUNT   = 2'd0;
   localparam logic [1:0] CSR_ONE_DUTY    = 2'd1;
   localparam logic [1:0] CSR_ZERO_DUTY   = 2'd2;
   localparam logic [1:0] CSR_LATCH_SLOTS = 2'd3;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] led_index;
      logic [7:0] range_last;
      logic [7:0] green;
      logic [7:0] red;
      logic [7:0] blue;
      logic [7:0] white;
   } req_type;

   typedef struct packed {
      logic              status;
      logic              slot_valid;
      logic [DUTY_W-1:0] duty;
      logic              frame_last;
      logic              busy_res;
   } rsp_type;

endpackage

// ===== rtl/rgbw_led_strip_slot_encoder.sv =====
// RGBW LED strip slot encoder: colour store, write commands and slot sequencer.
//
// Usage: the req channel (valid/stall) carries one command per item: set one LED,
// set all LEDs, set an inclusive range, or a slot tick. Every item gives exactly
// one rsp item. Writes update the 64-entry colour store and mark a frame pending;
// ticks step the frame out, one compare value per tick, each LED sending green,
// red, blue, white MSB first, then latch_slots slots of duty zero.
// Path of an item: set one, a bad index and an idle tick go from EXEC to DONE;
// a tick in the data phase goes EXEC, READ (store read is registered), SLOT,
// DONE, in the latch phase EXEC, SLOT, DONE; set all / set range that write
// LEDs pass through FILL between EXEC and DONE, one store write per cycle.
// One item is in work at a time; the next is taken when the FSM is in idle.
// The rsp register holds a finished item while rsp_stall is high; the next item
// is accepted and worked meanwhile and waits in its last state for the slot.
// Reset (synchronous, active high) reads the whole store as zero at once via
// per-entry valid bits, stops any frame and loads defaults: led_count 64, duties 0,
// latch_slots 50. The user writes the csr port only while idle (not enforced).
module rgbw_led_strip_slot_encoder (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  rgbw_enc_pkg::req_type       req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output rgbw_enc_pkg::rsp_type       rsp_data,
   input  logic                        csr_we,
   input  logic [1:0]                  csr_index,
   input  logic [rgbw_enc_pkg::CSR_W-1:0] csr_wdata
);
   import rgbw_enc_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001,
      ST_EXEC = 6'b000010,
      ST_FILL = 6'b000100,
      ST_READ = 6'b001000,
      ST_SLOT = 6'b010000,
      ST_DONE = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   req_type             item_ff, item_in;
   rsp_type             res_ff, res_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic [LED_W-1:0]    led_count_ff;
   logic [DUTY_W-1:0]   one_duty_ff;
   logic [DUTY_W-1:0]   zero_duty_ff;
   logic [7:0]          latch_slots_ff;

   logic                active_ff, active_in;
   logic                pending_ff, pending_in;
   logic [LED_W-1:0]    led_pos_ff, led_pos_in;
   logic [BIT_W-1:0]    bit_pos_ff, bit_pos_in;
   logic [7:0]          latch_ff, latch_in;
   logic [MEM_AW-1:0]   ptr_ff, ptr_in;
   logic [MEM_AW-1:0]   end_ff, end_in;

   logic [WORD_W-1:0]   mem [MAX_LEDS];
   logic [MAX_LEDS-1:0] valid_ff;
   logic [WORD_W-1:0]   rd_ff;
   logic                rdv_ff;

   logic                wr_en;
   logic [MEM_AW-1:0]   wr_addr;
   logic                rd_en;
   logic [WORD_W-1:0]   word;
   logic [LED_W-1:0]    n;
   logic                do_write;
   logic                start;
   logic                out_free;
   logic                slot_bit;

   assign n        = (led_count_ff > MAX_LEDS_V) ? MAX_LEDS_V : led_count_ff;
   assign word     = {item_ff.green, item_ff.red, item_ff.blue, item_ff.white};
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign slot_bit = rdv_ff & rd_ff[bit_pos_ff];

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      active_in    = active_ff;
      pending_in   = pending_ff;
      led_pos_in   = led_pos_ff;
      bit_pos_in   = bit_pos_ff;
      latch_in     = latch_ff;
      ptr_in       = ptr_ff;
      end_in       = end_ff;
      wr_en        = 1'b0;
      wr_addr      = ptr_ff;
      rd_en        = 1'b0;
      do_write     = 1'b0;
      start        = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            res_in   = '0;
            state_in = ST_DONE;
            unique case (item_ff.command)
               CMD_SET_ONE: begin
                  if (item_ff.led_index >= {1'b0, n}) begin
                     res_in.status = 1'b1;
                  end else begin
                     wr_en    = 1'b1;
                     wr_addr  = item_ff.led_index[MEM_AW-1:0];
                     do_write = 1'b1;
                  end
               end
               CMD_SET_ALL: begin
                  if (n == '0) begin
                     do_write = 1'b1;
                  end else begin
                     ptr_in   = '0;
                     end_in   = MEM_AW'(n - LED_W'(1));
                     state_in = ST_FILL;
                  end
               end
               CMD_SET_RANGE: begin
                  if (item_ff.led_index >= {1'b0, n} || item_ff.range_last >= {1'b0, n}) begin
                     res_in.status = 1'b1;
                  end else if (item_ff.led_index > item_ff.range_last) begin
                     do_write = 1'b1;
                  end else begin
                     ptr_in   = item_ff.led_index[MEM_AW-1:0];
                     end_in   = item_ff.range_last[MEM_AW-1:0];
                     state_in = ST_FILL;
                  end
               end
               CMD_TICK: begin
                  if (active_ff) begin
                     if (led_pos_ff < n) begin
                        rd_en    = 1'b1;
                        state_in = ST_READ;
                     end else begin
                        state_in = ST_SLOT;
                     end
                  end
               end
            endcase
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = ptr_ff;
            if (ptr_ff == end_ff) begin
               do_write = 1'b1;
               state_in = ST_DONE;
            end else begin
               ptr_in = ptr_ff + MEM_AW'(1);
            end
         end
         ST_READ: begin
            state_in = ST_SLOT;
         end
         ST_SLOT: begin
            res_in.slot_valid = 1'b1;
            if (led_pos_ff < n) begin
               res_in.duty = slot_bit ? one_duty_ff : zero_duty_ff;
               if (bit_pos_ff == '0) begin
                  bit_pos_in = BIT_TOP;
                  led_pos_in = led_pos_ff + LED_W'(1);
               end else begin
                  bit_pos_in = bit_pos_ff - BIT_W'(1);
               end
            end else begin
               res_in.duty = '0;
               latch_in    = (latch_ff == 8'hFF) ? latch_ff : latch_ff + 8'd1;
            end
            if (led_pos_in >= n && latch_in >= latch_slots_ff) begin
               res_in.frame_last = 1'b1;
               if (pending_ff) begin
                  start = 1'b1;
               end else begin
                  active_in = 1'b0;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in          = res_ff;
               rsp_data_in.busy_res = active_ff;
               state_in             = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // an accepted write starts a frame only when none is running
      if (do_write) begin
         pending_in = 1'b1;
         if (!active_ff) begin
            start = 1'b1;
         end
      end
      if (start) begin
         pending_in = 1'b0;
         led_pos_in = '0;
         bit_pos_in = BIT_TOP;
         latch_in   = '0;
         active_in  = !(n == '0 && latch_slots_ff == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         rsp_valid_ff   <= 1'b0;
         active_ff      <= 1'b0;
         pending_ff     <= 1'b0;
         led_pos_ff     <= '0;
         bit_pos_ff     <= BIT_TOP;
         latch_ff       <= '0;
         valid_ff       <= '0;
         led_count_ff   <= MAX_LEDS_V;
         one_duty_ff    <= '0;
         zero_duty_ff   <= '0;
         latch_slots_ff <= 8'd50;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         active_ff    <= active_in;
         pending_ff   <= pending_in;
         led_pos_ff   <= led_pos_in;
         bit_pos_ff   <= bit_pos_in;
         latch_ff     <= latch_in;
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_LED_COUNT:   led_count_ff   <= csr_wdata[LED_W-1:0];
               CSR_ONE_DUTY:    one_duty_ff    <= csr_wdata[DUTY_W-1:0];
               CSR_ZERO_DUTY:   zero_duty_ff   <= csr_wdata[DUTY_W-1:0];
               CSR_LATCH_SLOTS: latch_slots_ff <= csr_wdata[7:0];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff     <= item_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
      ptr_ff      <= ptr_in;
      end_ff      <= end_in;
   end

   // colour store; an entry never written since reset reads as zero
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= word;
      end
      if (rd_en) begin
         rd_ff  <= mem[led_pos_ff[MEM_AW-1:0]];
         rdv_ff <= valid_ff[led_pos_ff[MEM_AW-1:0]];
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_store_write_in_work: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == ST_EXEC || state_ff == ST_FILL))
      else $error("store written outside a write command");

   a_last_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_last) |-> rsp_data.slot_valid)
      else $error("frame_last on an item without a slot");

   a_duty_needs_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.duty != '0) |-> rsp_data.slot_valid)
      else $error("non-zero duty on an item without a slot");

   a_led_pos_bound: assert property (@(posedge clock) disable iff (reset)
      led_pos_ff <= MAX_LEDS_V)
      else $error("LED position beyond the store");

   a_read_before_slot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> $past(rd_en))
      else $error("slot read state entered without a store read");

endmodule

// ===== test/rgbw_led_strip_slot_encoder_tb.sv =====
// Self-checking testbench for the RGBW LED strip slot encoder.
module rgbw_led_strip_slot_encoder_tb;
   import rgbw_enc_pkg::*;

   localparam int QUIET_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 62;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   req_type             req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   rsp_type             rsp_data;
   logic                csr_we = 1'b0;
   logic [1:0]          csr_index = CSR_LED_COUNT;
   logic [CSR_W-1:0]    csr_wdata = '0;

   rgbw_led_strip_slot_encoder dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // Shadow of the block: colour store, frame sequencer and registers
   logic [WORD_W-1:0]  shadow_store [MAX_LEDS];
   logic               frame_active;
   logic               frame_pending;
   logic [LED_W-1:0]   led_pos;
   logic [BIT_W-1:0]   bit_pos;
   logic [7:0]         latch_cnt;
   logic [LED_W-1:0]   cfg_led_count;
   logic [DUTY_W-1:0]  cfg_one_duty;
   logic [DUTY_W-1:0]  cfg_zero_duty;
   logic [7:0]         cfg_latch_slots;

   req_type  cmd_queue[$];
   rsp_type  awaited_rsp[$];
   int       failures = 0;
   int       send_gap = 0;
   bit       send_calm = 1'b0;
   int       stall_left = 0;
   bit       recv_calm = 1'b0;
   int       quiet_cycles = 0;

   function automatic void restart_frame();
      logic [LED_W-1:0] n;
      n = (cfg_led_count > MAX_LEDS_V) ? MAX_LEDS_V : cfg_led_count;
      frame_pending = 1'b0;
      led_pos       = '0;
      bit_pos       = BIT_TOP;
      latch_cnt     = '0;
      frame_active  = !(n == 0 && cfg_latch_slots == 0);
   endfunction

   function automatic void mark_written();
      frame_pending = 1'b1;
      if (!frame_active)
         restart_frame();
   endfunction

   function automatic rsp_type encode_item(input req_type it);
      rsp_type           r;
      logic [LED_W-1:0]  n;
      logic [WORD_W-1:0] word;
      r    = '0;
      n    = (cfg_led_count > MAX_LEDS_V) ? MAX_LEDS_V : cfg_led_count;
      word = {it.green, it.red, it.blue, it.white};
      case (it.command)
         CMD_SET_ONE: begin
            if (it.led_index >= n) begin
               r.status = 1'b1;
            end else begin
               shadow_store[it.led_index[MEM_AW-1:0]] = word;
               mark_written();
            end
         end
         CMD_SET_ALL: begin
            for (int i = 0; i < n; i++)
               shadow_store[MEM_AW'(i)] = word;
            mark_written();
         end
         CMD_SET_RANGE: begin
            if (it.led_index >= n || it.range_last >= n) begin
               r.status = 1'b1;
            end else begin
               for (int i = it.led_index; i <= it.range_last; i++)
                  shadow_store[MEM_AW'(i)] = word;
               mark_written();
            end
         end
         default: begin
            if (frame_active) begin
               r.slot_valid = 1'b1;
               if (led_pos < n) begin
                  r.duty = shadow_store[led_pos[MEM_AW-1:0]][bit_pos] ? cfg_one_duty
                                                                      : cfg_zero_duty;
                  if (bit_pos == 0) begin
                     bit_pos = BIT_TOP;
                     led_pos++;
                  end else begin
                     bit_pos--;
                  end
               end else if (latch_cnt != 8'hFF) begin
                  latch_cnt++;
               end
               if (led_pos >= n && latch_cnt >= cfg_latch_slots) begin
                  r.frame_last = 1'b1;
                  if (frame_pending)
                     restart_frame();
                  else
                     frame_active = 1'b0;
               end
            end
         end
      endcase
      r.busy_res = frame_active;
      return r;
   endfunction

   // Driver: presents queued items, with a random gap after each accepted one
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_rsp.push_back(encode_item(req_data));
            if ($urandom_range(0, 39) == 0)
               send_calm = !send_calm;
            send_gap = send_calm ? 0 : $urandom_range(0, 6);
         end
         if (!(req_valid && req_stall)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (cmd_queue.size() != 0) begin
               req_valid <= 1'b1;
               req_data  <= cmd_queue.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks each result against the oldest prediction, stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               $error("result item with no prediction waiting");
               failures++;
            end else begin
               rsp_type want;
               want = awaited_rsp.pop_front();
               if (rsp_data.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.slot_valid !== want.slot_valid) begin
                  $error("slot_valid: expected %0d, got %0d",
                         want.slot_valid, rsp_data.slot_valid);
                  failures++;
               end
               if (rsp_data.duty !== want.duty) begin
                  $error("duty: expected %0h, got %0h", want.duty, rsp_data.duty);
                  failures++;
               end
               if (rsp_data.frame_last !== want.frame_last) begin
                  $error("frame_last: expected %0d, got %0d",
                         want.frame_last, rsp_data.frame_last);
                  failures++;
               end
               if (rsp_data.busy_res !== want.busy_res) begin
                  $error("busy_res: expected %0d, got %0d", want.busy_res, rsp_data.busy_res);
                  failures++;
               end
            end
            if ($urandom_range(0, 39) == 0)
               recv_calm = !recv_calm;
            stall_left = recv_calm ? 0 : $urandom_range(0, 6);
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Watchdog on cycles with no item moving on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic req_type mk_item(input logic [1:0] cmd, input logic [7:0] first,
                                       input logic [7:0] last, input logic [31:0] word);
      req_type it;
      it.command    = cmd;
      it.led_index  = first;
      it.range_last = last;
      {it.green, it.red, it.blue, it.white} = word;
      return it;
   endfunction

   function automatic logic [7:0] pick_led(input int n);
      if (n == 0 || $urandom_range(0, 9) == 0)
         return 8'($urandom_range(0, 255));
      return 8'($urandom_range(0, n - 1));
   endfunction

   function automatic req_type random_item(input int n);
      req_type     it;
      logic [63:0] raw;
      int          pick;
      raw  = {$urandom(), $urandom()};
      it   = raw[$bits(req_type)-1:0];
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
         0:       {it.green, it.red, it.blue, it.white} = '0;
         1:       {it.green, it.red, it.blue, it.white} = '1;
         default: ;
      endcase
      if (pick < 62) begin
         it.command = CMD_TICK;
      end else if (pick < 76) begin
         it.command   = CMD_SET_ONE;
         it.led_index = pick_led(n);
      end else if (pick < 84) begin
         it.command = CMD_SET_ALL;
      end else begin
         it.command    = CMD_SET_RANGE;
         it.led_index  = pick_led(n);
         it.range_last = pick_led(n);
      end
      return it;
   endfunction

   task automatic drain();
      do
         @(negedge clock);
      while (cmd_queue.size() != 0 || req_valid || awaited_rsp.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_regs(input logic [LED_W-1:0] cnt, input logic [DUTY_W-1:0] one,
                             input logic [DUTY_W-1:0] zero, input logic [7:0] latch);
      @(posedge clock);
      csr_we        <= 1'b1;
      csr_index     <= CSR_LED_COUNT;
      csr_wdata     <= CSR_W'(cnt);
      cfg_led_count = cnt;
      @(posedge clock);
      csr_index     <= CSR_ONE_DUTY;
      csr_wdata     <= one;
      cfg_one_duty  = one;
      @(posedge clock);
      csr_index     <= CSR_ZERO_DUTY;
      csr_wdata     <= zero;
      cfg_zero_duty = zero;
      @(posedge clock);
      csr_index     <= CSR_LATCH_SLOTS;
      csr_wdata     <= CSR_W'(latch);
      cfg_latch_slots = latch;
      @(posedge clock);
      csr_we        <= 1'b0;
      @(negedge clock);
   endtask

   initial begin
      int n;
      foreach (shadow_store[i])
         shadow_store[i] = '0;
      frame_active    = 1'b0;
      frame_pending   = 1'b0;
      led_pos         = '0;
      bit_pos         = BIT_TOP;
      latch_cnt       = '0;
      cfg_led_count   = 7'd64;
      cfg_one_duty    = '0;
      cfg_zero_duty   = '0;
      cfg_latch_slots = 8'd50;

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Defaults: index limits at the full strip, reversed range, idle tick
      cmd_queue.push_back(mk_item(CMD_TICK, 8'd0, 8'd0, 32'h0));
      cmd_queue.push_back(mk_item(CMD_SET_ONE, 8'd64, 8'd0, 32'hFFFF_FFFF));
      cmd_queue.push_back(mk_item(CMD_SET_ONE, 8'd255, 8'd255, 32'h1234_5678));
      cmd_queue.push_back(mk_item(CMD_SET_RANGE, 8'd0, 8'd64, 32'hFFFF_FFFF));
      cmd_queue.push_back(mk_item(CMD_SET_RANGE, 8'd200, 8'd3, 32'hFFFF_FFFF));
      cmd_queue.push_back(mk_item(CMD_SET_RANGE, 8'd63, 8'd0, 32'hDEAD_BEEF));
      cmd_queue.push_back(mk_item(CMD_SET_ONE, 8'd63, 8'd0, 32'hFFFF_FFFF));
      cmd_queue.push_back(mk_item(CMD_SET_RANGE, 8'd0, 8'd63, 32'h0000_0000));
      cmd_queue.push_back(mk_item(CMD_SET_ALL, 8'd0, 8'd0, 32'h8000_0001));
      cmd_queue.push_back(mk_item(CMD_TICK, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
      cmd_queue.push_back(mk_item(CMD_TICK, 8'd0, 8'd0, 32'h0));
      drain();

      // Strip cut to three LEDs mid-frame; writes land in bits not yet sent
      write_regs(7'd3, 16'hFFFF, 16'h0000, 8'd2);
      cmd_queue.push_back(mk_item(CMD_SET_ONE, 8'd2, 8'd0, 32'hA5C3_0FF0));
      cmd_queue.push_back(mk_item(CMD_SET_RANGE, 8'd0, 8'd1, 32'h7FFF_FFFE));
      cmd_queue.push_back(mk_item(CMD_SET_ONE, 8'd0, 8'd0, 32'h5A3C_F00F));
      repeat (4) cmd_queue.push_back(mk_item(CMD_TICK, 8'd0, 8'd0, 32'h0));
      drain();

      // No LEDs and no latch slots: frame ends on the next tick, then empty frames
      write_regs(7'd0, 16'h1234, 16'hFFFF, 8'd0);
      cmd_queue.push_back(mk_item(CMD_TICK, 8'd0, 8'd0, 32'h0));
      cmd_queue.push_back(mk_item(CMD_SET_ALL, 8'd0, 8'd0, 32'hFFFF_FFFF));
      cmd_queue.push_back(mk_item(CMD_SET_ONE, 8'd0, 8'd0, 32'hFFFF_FFFF));
      cmd_queue.push_back(mk_item(CMD_SET_RANGE, 8'd0, 8'd0, 32'hFFFF_FFFF));
      cmd_queue.push_back(mk_item(CMD_TICK, 8'd0, 8'd0, 32'h0));
      drain();

      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: write_regs(7'd1, 16'hFFFF, 16'h0000, 8'd0);
            1: write_regs(7'd2, 16'($urandom), 16'($urandom), 8'd3);
            2: write_regs(7'd0, 16'($urandom), 16'($urandom), 8'd5);  // latch-only frames
            3: write_regs(7'd4, 16'h0000, 16'hFFFF, 8'd1);
            4: write_regs(7'd64, 16'($urandom), 16'($urandom), 8'd2);
            5: write_regs(7'd2, 16'($urandom), 16'($urandom), 8'd0);  // count cut mid-frame
            6: write_regs(7'd100, 16'($urandom), 16'($urandom), 8'd4); // above store size
            7: write_regs(7'd3, 16'($urandom), 16'($urandom), 8'd255);
            8: write_regs(7'd0, 16'($urandom), 16'($urandom), 8'd0);  // empty frames
            default: write_regs(7'(1 + $urandom_range(0, 2)), 16'($urandom),
                                16'($urandom), 8'($urandom_range(0, 6)));
         endcase
         n = (cfg_led_count > MAX_LEDS_V) ? MAX_LEDS : int'(cfg_led_count);
         repeat (PHASE_ITEMS) cmd_queue.push_back(random_item(n));
         drain();
      end

      if (failures == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
